// File: rtl/core/chtb_pkg.sv
// shared constants, codes and result word type for the chained hash table
package chtb_pkg;

  localparam int DEF_BUCKETS       = 1024;
  localparam int DEF_ENTRIES       = 1024;
  localparam int DEF_MAX_KEY_BYTES = 8;

  localparam int KEY_W    = 64;
  localparam int PAY_W    = 16;
  localparam int LEN_W    = 4;
  localparam int BCNT_W   = 11;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [7:0] HASH_MULT = 8'd131;

  localparam logic [LEN_W-1:0]  KEY_LEN_RST = 4'd8;
  localparam logic [BCNT_W-1:0] BKT_CNT_RST = 11'd53;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BKT_CNT = 1'b1;

  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAY_W-1:0]    found_payload;
    logic                prev_last_valid;
    logic [PAY_W-1:0]    prev_last_payload;
    logic [PAY_W-1:0]    first_payload;
  } res_t;

endpackage

// File: rtl/core/chained_hash_table_bkdr.sv
// top level of the chained hash table with bkdr bucket hash
//
//  channel  ports                         direction  accepted when
//  input    in_push/in_full, in_*         in         in_push && !in_full
//  result   out_empty/out_pop, out_*      out        out_pop && !out_empty
//  config   cfg_valid/cfg_ready, cfg_*    in         cfg_valid && cfg_ready
//
// the front hashes one bit of 131 and of the key byte per cycle, byte after
// byte up to the key length, then queues the word once the queue has room
// the back reads the bucket head, then writes an insert or walks a chain on a find
// after reset the head memory is swept, one bucket a cycle, over all buckets;
// in_full stays high meanwhile
// a waiting result does not stop the front; the back holds its next word until
// the result register has room
module chained_hash_table_bkdr import chtb_pkg::*; #(
  parameter int BUCKETS       = DEF_BUCKETS,
  parameter int ENTRIES       = DEF_ENTRIES,
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_op,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [PAY_W-1:0]     in_payload,
  // result words
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [STATUS_W-1:0]  out_status,
  output logic [PAY_W-1:0]     out_found_payload,
  output logic                 out_prev_last_valid,
  output logic [PAY_W-1:0]     out_prev_last_payload,
  output logic [PAY_W-1:0]     out_first_payload,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BCNT_W-1:0]    cfg_wdata
);

  localparam int HW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int MW = $clog2(BUCKETS + 1);
  localparam int QW = 1 + KEY_W + PAY_W + HW;

  logic [LEN_W-1:0]  klen_r, klen_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [LEN_W-1:0]  len_eff;
  logic [MW-1:0]     mod_eff;
  logic              front_busy, clearing, in_acc;
  logic              q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]     q_wdata, q_rdata;
  logic              res_valid;
  res_t              res;

  // registers are always writable; the user must make writes only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_comb begin
    klen_nxt = klen_r;
    bcnt_nxt = bcnt_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_KEY_LEN: klen_nxt = cfg_wdata[LEN_W-1:0];
        CFG_BKT_CNT: bcnt_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= KEY_LEN_RST;
      bcnt_r <= BKT_CNT_RST;
    end else begin
      klen_r <= klen_nxt;
      bcnt_r <= bcnt_nxt;
    end
  end

  // zero means one, above the limits clamps to the limit
  always_comb begin
    if (klen_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (klen_r > LEN_W'(MAX_KEY_BYTES)) begin
      len_eff = LEN_W'(MAX_KEY_BYTES);
    end else begin
      len_eff = klen_r;
    end
    if (bcnt_r == '0) begin
      mod_eff = MW'(1);
    end else if (32'(bcnt_r) > 32'(BUCKETS)) begin
      mod_eff = MW'(BUCKETS);
    end else begin
      mod_eff = MW'(bcnt_r);
    end
  end

  assign in_full = front_busy || clearing;
  assign in_acc  = in_push && !in_full;

  chtb_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .op      (in_op),
    .key     (in_key),
    .payload (in_payload),
    .len     (len_eff),
    .modv    (mod_eff),
    .busy    (front_busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // short queue so hashing continues while the back walks a chain
  chtb_fifo #(
    .DW (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  chtb_back #(
    .BUCKETS       (BUCKETS),
    .ENTRIES       (ENTRIES),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .len       (len_eff),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (out_pop)
  );

  // result register drives the ports directly
  assign out_empty             = !res_valid;
  assign out_status            = res.status;
  assign out_found_payload     = res.found_payload;
  assign out_prev_last_valid   = res.prev_last_valid;
  assign out_prev_last_payload = res.prev_last_payload;
  assign out_first_payload     = res.first_payload;

endmodule

// File: rtl/core/chtb_fifo.sv
// two-entry queue between the hash front and the table back
module chtb_fifo import chtb_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  logic [DW-1:0] mem_r [2];
  logic          wptr_r, wptr_nxt;
  logic          rptr_r, rptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? !wptr_r : wptr_r;
    rptr_nxt = do_pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/core/chtb_front.sv
// front end: takes a word and computes its bucket one hash bit per cycle
module chtb_front import chtb_pkg::*; #(
  parameter int BUCKETS       = DEF_BUCKETS,
  localparam int HW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
  localparam int MW = $clog2(BUCKETS + 1),
  localparam int QW = 1 + KEY_W + PAY_W + HW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic             op,
  input  logic [KEY_W-1:0] key,
  input  logic [PAY_W-1:0] payload,
  input  logic [LEN_W-1:0] len,
  input  logic [MW-1:0]    modv,
  output logic             busy,
  input  logic             q_full,
  output logic             q_push,
  output logic [QW-1:0]    q_data
);

  localparam int SW = MW + 2;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic             op_r;
  logic [KEY_W-1:0] key_r, ksh_r, ksh_nxt;
  logic [PAY_W-1:0] pay_r;
  logic [7:0]       byte_r, byte_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [HW-1:0]    hb_r, hb_nxt;
  logic [HW-1:0]    acc_r, acc_nxt;
  logic [SW-1:0]    sum, m1, m2, red;

  assign busy   = (state_r != F_IDLE);
  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_data = {hb_r, op_r, key_r, pay_r};

  // horner step over the bits of 131 and of the key byte together
  always_comb begin
    m1  = SW'(modv);
    m2  = m1 << 1;
    sum = (SW'(acc_r) << 1) + (HASH_MULT[~bit_r] ? SW'(hb_r) : '0) + SW'(byte_r[7]);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ksh_nxt   = ksh_r;
    byte_nxt  = byte_r;
    bit_nxt   = bit_r;
    left_nxt  = left_r;
    hb_nxt    = hb_r;
    acc_nxt   = acc_r;
    case (state_r)
      F_IDLE: begin
        if (acc) begin
          state_nxt = F_HASH;
          ksh_nxt   = key >> 8;
          byte_nxt  = key[7:0];
          bit_nxt   = 3'd0;
          left_nxt  = len;
          hb_nxt    = '0;
          acc_nxt   = '0;
        end
      end
      F_HASH: begin
        bit_nxt  = bit_r + 3'd1;
        byte_nxt = byte_r << 1;
        acc_nxt  = HW'(red);
        if (bit_r == 3'd7) begin
          // byte done: its residue seeds the next byte
          hb_nxt   = HW'(red);
          acc_nxt  = '0;
          byte_nxt = ksh_r[7:0];
          ksh_nxt  = ksh_r >> 8;
          left_nxt = left_r - LEN_W'(1);
          if (left_r == LEN_W'(1)) begin
            state_nxt = F_PUSH;
          end
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && state_r == F_IDLE) begin
      op_r  <= op;
      key_r <= key;
      pay_r <= payload;
    end
    ksh_r  <= ksh_nxt;
    byte_r <= byte_nxt;
    bit_r  <= bit_nxt;
    left_r <= left_nxt;
    hb_r   <= hb_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

// File: rtl/core/chtb_back.sv
// back end: bucket heads, entry pool, chain walk and result register
module chtb_back import chtb_pkg::*; #(
  parameter int BUCKETS       = DEF_BUCKETS,
  parameter int ENTRIES       = DEF_ENTRIES,
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES,
  localparam int HW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
  localparam int QW = 1 + KEY_W + PAY_W + HW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] len,
  input  logic             q_empty,
  input  logic [QW-1:0]    q_data,
  output logic             q_pop,
  output logic             clearing,
  output logic             res_valid,
  output res_t             res,
  input  logic             res_pop
);

  localparam int EW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);
  localparam int KW = 8 * MAX_KEY_BYTES;
  localparam logic [EW-1:0] NO_ENTRY = EW'(ENTRIES);
  localparam logic [HW-1:0] LAST_BKT = HW'(BUCKETS - 1);

  typedef enum logic [3:0] {
    B_CLEAR = 4'b0001,
    B_IDLE  = 4'b0010,
    B_HEAD  = 4'b0100,
    B_WALK  = 4'b1000
  } bstate_t;

  logic [EW-1:0]    heads_mem [BUCKETS];
  logic [KW-1:0]    keys_mem  [ENTRIES];
  logic [PAY_W-1:0] pays_mem  [ENTRIES];
  logic [EW-1:0]    links_mem [ENTRIES];

  bstate_t          state_r, state_nxt;
  logic [HW-1:0]    clr_r, clr_nxt;
  logic             op_r;
  logic [KW-1:0]    key_r;
  logic [PAY_W-1:0] pay_r;
  logic [HW-1:0]    bkt_r;
  logic [EW-1:0]    used_r, used_nxt;
  logic [PAY_W-1:0] first_r, first_nxt, last_r, last_nxt;
  logic             nonempty_r, nonempty_nxt;
  logic             res_v_r, res_v_nxt;
  res_t             res_r, res_nxt;
  logic [EW-1:0]    head_q_r;
  logic [KW-1:0]    ekey_q_r;
  logic [PAY_W-1:0] epay_q_r;
  logic [EW-1:0]    elink_q_r;
  logic [IW-1:0]    ent_ra_r, ent_ra_nxt;

  logic             head_we, head_re, ent_we, ent_re, take, match;
  logic [HW-1:0]    head_wa;
  logic [EW-1:0]    head_wd;

  assign clearing  = (state_r == B_CLEAR);
  assign res_valid = res_v_r;
  assign res       = res_r;
  assign take      = (state_r == B_IDLE) && !q_empty && (!res_v_r || res_pop);
  assign q_pop     = take;
  assign head_re   = take;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      if (LEN_W'(i) < len && ekey_q_r[8*i +: 8] != key_r[8*i +: 8]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    used_nxt     = used_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    nonempty_nxt = nonempty_r;
    res_nxt      = res_r;
    res_v_nxt    = res_v_r && !res_pop;
    ent_ra_nxt   = ent_ra_r;
    head_we      = 1'b0;
    head_wa      = bkt_r;
    head_wd      = used_r;
    ent_we       = 1'b0;
    ent_re       = 1'b0;
    case (state_r)
      B_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_r;
        head_wd = NO_ENTRY;
        clr_nxt = clr_r + HW'(1);
        if (clr_r == LAST_BKT) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (take) begin
          state_nxt = B_HEAD;
        end
      end
      B_HEAD: begin
        res_nxt.status            = ST_OK;
        res_nxt.found_payload     = '0;
        res_nxt.prev_last_valid   = 1'b0;
        res_nxt.prev_last_payload = '0;
        res_nxt.first_payload     = first_r;
        if (op_r == OP_INSERT) begin
          state_nxt = B_IDLE;
          res_v_nxt = 1'b1;
          if (used_r == NO_ENTRY) begin
            res_nxt.status = ST_FULL;
          end else begin
            head_we    = 1'b1;
            ent_we     = 1'b1;
            used_nxt   = used_r + EW'(1);
            ent_ra_nxt = IW'(used_r);
            if (nonempty_r) begin
              res_nxt.prev_last_valid   = 1'b1;
              res_nxt.prev_last_payload = last_r;
            end else begin
              first_nxt             = pay_r;
              res_nxt.first_payload = pay_r;
            end
            nonempty_nxt = 1'b1;
            last_nxt     = pay_r;
          end
        end else if (head_q_r == NO_ENTRY) begin
          state_nxt      = B_IDLE;
          res_v_nxt      = 1'b1;
          res_nxt.status = ST_NOT_FOUND;
        end else begin
          state_nxt  = B_WALK;
          ent_re     = 1'b1;
          ent_ra_nxt = IW'(head_q_r);
        end
      end
      B_WALK: begin
        if (match) begin
          state_nxt             = B_IDLE;
          res_v_nxt             = 1'b1;
          res_nxt.found_payload = epay_q_r;
        end else if (elink_q_r == NO_ENTRY) begin
          state_nxt      = B_IDLE;
          res_v_nxt      = 1'b1;
          res_nxt.status = ST_NOT_FOUND;
        end else begin
          ent_re     = 1'b1;
          ent_ra_nxt = IW'(elink_q_r);
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_CLEAR;
      clr_r      <= '0;
      used_r     <= '0;
      first_r    <= '0;
      last_r     <= '0;
      nonempty_r <= 1'b0;
      res_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      used_r     <= used_nxt;
      first_r    <= first_nxt;
      last_r     <= last_nxt;
      nonempty_r <= nonempty_nxt;
      res_v_r    <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    ent_ra_r <= ent_ra_nxt;
    if (take) begin
      bkt_r <= q_data[QW-1 -: HW];
      op_r  <= q_data[KEY_W + PAY_W];
      key_r <= q_data[PAY_W +: KW];
      pay_r <= q_data[PAY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      heads_mem[head_wa] <= head_wd;
    end
    if (head_re) begin
      head_q_r <= heads_mem[q_data[QW-1 -: HW]];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      keys_mem[IW'(used_r)]  <= key_r;
      pays_mem[IW'(used_r)]  <= pay_r;
      links_mem[IW'(used_r)] <= head_q_r;
    end
    if (ent_re) begin
      ekey_q_r  <= keys_mem[ent_ra_nxt];
      epay_q_r  <= pays_mem[ent_ra_nxt];
      elink_q_r <= links_mem[ent_ra_nxt];
    end
  end

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= NO_ENTRY)
    else $error("pool count past capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_HEAD && op_r == OP_INSERT && used_r != NO_ENTRY)
      |=> used_r == $past(used_r) + EW'(1))
    else $error("insert did not take a pool entry");

  a_walk_written: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_WALK) |-> (EW'(ent_ra_r) < used_r))
    else $error("chain walk reached an unwritten entry");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && !res_pop) |=> $stable(res_r))
    else $error("waiting result word changed");
`endif

endmodule

// File: sim/tb_top.sv
// self-checking testbench for the chained hash table with bkdr bucket hash
module tb_top;
  import chtb_pkg::*;

  localparam int NBKT = DEF_BUCKETS;
  localparam int NENT = DEF_ENTRIES;
  localparam int MAXLEN = DEF_MAX_KEY_BYTES;
  localparam int WDOG_LIMIT = 20000;

  // predictor of the table: owns its own copy of the chains and the order list
  class hash_scoreboard;
    int unsigned len_reg;
    int unsigned bkt_reg;
    int unsigned heads[NBKT];
    logic [KEY_W-1:0] keys[NENT];
    logic [PAY_W-1:0] pays[NENT];
    int unsigned links[NENT];
    int unsigned used;
    logic [PAY_W-1:0] first_pay, last_pay;
    bit list_live;
    res_t pending[$];
    int errors;
    int checked;

    function void clear();
      len_reg = KEY_LEN_RST;
      bkt_reg = BKT_CNT_RST;
      foreach (heads[i]) heads[i] = NENT;
      used = 0;
      first_pay = '0;
      last_pay = '0;
      list_live = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BCNT_W-1:0] val);
      if (idx == CFG_KEY_LEN) len_reg = val[LEN_W-1:0];
      else bkt_reg = val;
    endfunction

    // bucket index from the key bytes, taken unsigned
    function int unsigned bucket_of(logic [KEY_W-1:0] k, int unsigned n, int unsigned m);
      longint unsigned h;
      h = 0;
      for (int i = 0; i < n; i++) h = (h * 131 + k[8*i +: 8]) % m;
      return 32'(h);
    endfunction

    function void note_word(logic op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
      int unsigned n, m, b, e, steps;
      logic [KEY_W-1:0] km;
      res_t r;
      n = (len_reg == 0) ? 1 : (len_reg > MAXLEN ? MAXLEN : len_reg);
      m = (bkt_reg == 0) ? 1 : (bkt_reg > NBKT ? NBKT : bkt_reg);
      b = bucket_of(k, n, m);
      km = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      r = '0;
      r.status = ST_NOT_FOUND;
      if (op == OP_FIND) begin
        e = heads[b];
        steps = 0;
        while (e < NENT && steps < NENT) begin
          if (((keys[e] ^ k) & km) == 0) begin
            r.status = ST_OK;
            r.found_payload = pays[e];
            break;
          end
          e = links[e];
          steps++;
        end
      end else if (used >= NENT) begin
        r.status = ST_FULL;
      end else begin
        keys[used] = k;
        pays[used] = p;
        links[used] = heads[b];
        heads[b] = used;
        used++;
        if (list_live) begin
          r.prev_last_valid = 1'b1;
          r.prev_last_payload = last_pay;
        end else begin
          first_pay = p;
          list_live = 1'b1;
        end
        last_pay = p;
        r.status = ST_OK;
      end
      r.first_payload = first_pay;
      pending.push_back(r);
    endfunction

    function void check_word(res_t got);
      res_t exp;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
      if (got.found_payload !== exp.found_payload)
        $display("%0t: found_payload exp %h got %h", $time, exp.found_payload,
                 got.found_payload);
      if (got.prev_last_valid !== exp.prev_last_valid)
        $display("%0t: prev_last_valid exp %b got %b", $time, exp.prev_last_valid,
                 got.prev_last_valid);
      if (got.prev_last_payload !== exp.prev_last_payload)
        $display("%0t: prev_last_payload exp %h got %h", $time, exp.prev_last_payload,
                 got.prev_last_payload);
      if (got.first_payload !== exp.first_payload)
        $display("%0t: first_payload exp %h got %h", $time, exp.first_payload,
                 got.first_payload);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_push, in_full, in_op;
  logic [KEY_W-1:0] in_key;
  logic [PAY_W-1:0] in_payload;
  logic out_empty, out_pop;
  logic [STATUS_W-1:0] out_status;
  logic [PAY_W-1:0] out_found_payload, out_prev_last_payload, out_first_payload;
  logic out_prev_last_valid;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BCNT_W-1:0] cfg_wdata;

  chained_hash_table_bkdr uut (.*);

  hash_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  bit recv_hold;          // long receiver stall in progress
  int watchdog;
  int n_words, n_inserts, n_full;
  // recently inserted keys, so finds can hit
  logic [KEY_W-1:0] key_pool[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      watchdog <= 0;
    else
      watchdog <= watchdog + 1;
    if (watchdog >= WDOG_LIMIT) begin
      $display("watchdog expired");
      $display("tb_top: errors");
      $finish;
    end
  end

  // result side: sample on the rising edge, pop changes on the falling edge
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_word('{out_status, out_found_payload, out_prev_last_valid,
                      out_prev_last_payload, out_first_payload});
  end

  always @(negedge clk) begin
    if (!rst_n || recv_hold) out_pop <= 0;
    else out_pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one input word, held until the block takes it; push stays up for the next one
  task automatic push_word(logic op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
    bit was_full;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 0;
      @(negedge clk);
    end
    in_push <= 1;
    in_op <= op;
    in_key <= k;
    in_payload <= p;
    @(posedge clk);
    while (in_full) @(posedge clk);
    was_full = (sb.used >= NENT);
    sb.note_word(op, k, p);
    n_words++;
    if (op == OP_INSERT) begin
      n_inserts++;
      if (was_full) n_full++;
      key_pool.push_back(k);
      if (key_pool.size() > 64) void'(key_pool.pop_front());
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_push <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BCNT_W-1:0] val);
    in_push <= 0;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // finds and inserts of known and of random keys, known keys sometimes with junk in the upper four bytes
  task automatic random_words(int count);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < count; i++) begin
      if (key_pool.size() != 0 && $urandom_range(99) < 45) begin
        k = key_pool[$urandom_range(key_pool.size() - 1)];
        if ($urandom_range(3) == 0) k[63:32] = $urandom;
        push_word($urandom_range(4) == 0 ? OP_INSERT : OP_FIND, k, PAY_W'($urandom));
      end else begin
        k = rand_key();
        if ($urandom_range(3) == 0) k = KEY_W'($urandom_range(3));
        push_word($urandom_range(1) ? OP_INSERT : OP_FIND, k, PAY_W'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n = 0;
    in_push = 0; in_op = 0; in_key = '0; in_payload = '0;
    out_pop = 0; cfg_valid = 0; cfg_index = '0; cfg_wdata = '0;
    recv_hold = 0; watchdog = 0;
    n_words = 0; n_inserts = 0; n_full = 0;
    send_idle_pct = 9; recv_idle_pct = 83;
    repeat (4) @(negedge clk);
    rst_n <= 1;

    // directed: reset settings, find on an empty table, field extremes
    push_word(OP_FIND, '0, '0);
    push_word(OP_INSERT, '0, '0);
    push_word(OP_INSERT, '1, 16'hffff);
    push_word(OP_INSERT, '1, 16'h1234);
    push_word(OP_FIND, '1, '0);
    push_word(OP_FIND, '0, '0);
    push_word(OP_FIND, 64'h8080_8080_8080_8080, 16'h5555);
    push_word(OP_INSERT, 64'h8080_8080_8080_8080, 16'haaaa);
    push_word(OP_FIND, 64'h8080_8080_8080_8080, '0);
    drain();

    // zero length acts as one byte, zero buckets as one bucket
    write_reg(CFG_KEY_LEN, BCNT_W'(0));
    write_reg(CFG_BKT_CNT, BCNT_W'(0));
    push_word(OP_FIND, 64'hdead_beef_0000_00ff, '0);   // matches the all-ones key
    push_word(OP_INSERT, 64'h11, 16'h0101);
    push_word(OP_FIND, 64'hffff_ffff_ffff_ff11, '0);
    drain();
    // above the limits: length 15, 2047 buckets
    write_reg(CFG_KEY_LEN, BCNT_W'(15));
    write_reg(CFG_BKT_CNT, BCNT_W'(2047));
    push_word(OP_FIND, 64'h11, '0);                    // earlier entry now hidden
    push_word(OP_INSERT, 64'h0123_4567_89ab_cdef, 16'h00ff);
    push_word(OP_FIND, 64'h0123_4567_89ab_cdef, '0);
    drain();
    write_reg(CFG_BKT_CNT, BCNT_W'(NBKT));
    write_reg(CFG_KEY_LEN, BCNT_W'(1));
    push_word(OP_FIND, 64'hef, '0);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_KEY_LEN, BCNT_W'($urandom_range(1, 8)));
      write_reg(CFG_BKT_CNT, BCNT_W'(ph == 0 ? 1 :
                                     (ph == 1 ? NBKT : $urandom_range(1, 200))));
      if (ph == 2) begin send_idle_pct = 83; recv_idle_pct = 9; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (ph == 3) begin
        // receiver holds off while the sender keeps going, block fills up
        fork
          begin
            recv_hold = 1;
            repeat (3000) @(negedge clk);
            recv_hold = 0;
          end
          random_words(60);
        join
      end
      random_words(125);
      drain();   // sender pauses until every result has come
    end

    // exhaust the pool so inserts report full
    write_reg(CFG_KEY_LEN, BCNT_W'(8));
    write_reg(CFG_BKT_CNT, BCNT_W'(997));
    while (sb.used < NENT) push_word(OP_INSERT, rand_key(), PAY_W'($urandom));
    random_words(40);
    drain();

    $display("covered %0d words, %0d inserts (%0d at full pool), %0d results checked",
             n_words, n_inserts, n_full, sb.checked);
    $display("settings from one byte and one bucket up to full length and 1024 buckets");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
